// File: sv/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset masking
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Implication built on the clocked form
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    `ASSERT_CLKD(lbl, clk, rstn, (ante) |-> (cons))

`endif

// File: sv/sgcw_pkg.sv
package sgcw_pkg;

    localparam int WIN_W = 3;
    localparam int OFF_W = 4;
    localparam logic [WIN_W-1:0] WIN_RESET = 3'd2;
    localparam logic signed [OFF_W-1:0] K_ONE = 4'sd1;
    localparam logic signed [OFF_W-1:0] K_NEG1 = -4'sd1;

    typedef struct packed {
        logic load;
        logic start;
        logic emit;
        logic step;
        logic next_c;
        logic finish;
    } sgcw_cmd_t;

    typedef struct packed {
        logic center_ok;
        logic k_last;
        logic out_free;
    } sgcw_stat_t;

endpackage

// File: sv/sgcw_ctrl.sv
module sgcw_ctrl
    import sgcw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sgcw_stat_t stat,
    output sgcw_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   rdy_reg, rdy_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        rdy_next   = rdy_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && rdy_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                    rdy_next   = 1'b0;
                end
            end
            ST_CHECK: begin
                if (stat.center_ok) begin
                    cmd.start  = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    rdy_next   = 1'b1;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.k_last) begin
                        cmd.next_c = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                rdy_next   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rdy_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;
            rdy_reg   <= rdy_next;
        end
    end

    assign in_ready = rdy_reg;

endmodule

// File: sv/sgcw_dpath.sv
module sgcw_dpath
    import sgcw_pkg::*;
#(
    parameter int MAX_WINDOW = 4,
    parameter int ID_BITS    = 16,
    parameter int POS_BITS   = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [WIN_W-1:0]           cfg_wr_data,
    input  logic [ID_BITS-1:0]         in_token,
    input  logic                       in_last,
    input  sgcw_cmd_t                  cmd,
    output sgcw_stat_t                 stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ID_BITS-1:0]         out_center_id,
    output logic [POS_BITS-1:0]        out_cpos,
    output logic [ID_BITS-1:0]         out_context_id,
    output logic signed [OFF_W-1:0]    out_rel_offset,
    output logic                       out_has_context,
    output logic                       out_center_done,
    output logic                       out_run_last
);

    localparam int HIST_DEPTH = 2 * MAX_WINDOW + 1;
    localparam int HI_W       = $clog2(HIST_DEPTH);
    localparam int DC_SAT     = HIST_DEPTH + MAX_WINDOW;
    localparam int DC_W       = $clog2(DC_SAT + 1);
    localparam int DIST_W     = DC_W + 2;
    localparam logic [WIN_W-1:0]    WIN_MAX = WIN_W'(MAX_WINDOW);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [WIN_W-1:0]          win_reg;
    logic [ID_BITS-1:0]        hist_reg [HIST_DEPTH];
    logic [POS_BITS-1:0]       count_reg;
    logic [POS_BITS-1:0]       last_reg;
    logic [POS_BITS-1:0]       c_reg;
    logic                      flush_reg;
    logic [DC_W-1:0]           dc_reg;
    logic signed [OFF_W-1:0]   k_reg;
    logic signed [OFF_W-1:0]   k_end_reg;
    logic                      empty_reg;
    logic [ID_BITS-1:0]        cid_reg;
    logic                      m_valid_reg;

    logic [WIN_W-1:0]          w_eff;
    logic                      sat;
    logic [POS_BITS-1:0]       last_next;
    logic [POS_BITS-1:0]       d_c;
    logic [DC_W-1:0]           dc_sat;
    logic [WIN_W-1:0]          lo_mag;
    logic [WIN_W-1:0]          hi_mag;
    logic                      empty_now;
    logic signed [OFF_W-1:0]   k_lo;
    logic signed [OFF_W-1:0]   k_first;
    logic signed [OFF_W-1:0]   k_end;
    logic signed [OFF_W-1:0]   k_step;
    logic signed [DIST_W-1:0]  k_ext;
    logic signed [DIST_W-1:0]  nb_dist;
    logic signed [DIST_W-1:0]  rd_dist;
    logic                      rd_ok;
    logic [HI_W-1:0]           rd_idx;
    logic [ID_BITS-1:0]        rd_data;
    logic                      k_last;
    logic                      next_ok;

    always_comb begin
        if (win_reg == '0) begin
            w_eff = WIN_W'(1);
        end else if (win_reg > WIN_MAX) begin
            w_eff = WIN_MAX;
        end else begin
            w_eff = win_reg;
        end
    end

    assign sat       = (count_reg == POS_MAX);
    assign last_next = sat ? (count_reg - POS_BITS'(1)) : count_reg;

    assign d_c    = last_reg - c_reg;
    assign dc_sat = (d_c >= POS_BITS'(DC_SAT)) ? DC_W'(DC_SAT) : d_c[DC_W-1:0];

    assign stat.center_ok = (c_reg <= last_reg) &&
                            (flush_reg || (d_c >= POS_BITS'(w_eff)));

    assign lo_mag    = (c_reg >= POS_BITS'(w_eff)) ? w_eff : c_reg[WIN_W-1:0];
    assign hi_mag    = (dc_sat >= DC_W'(w_eff)) ? w_eff : dc_sat[WIN_W-1:0];
    assign empty_now = (lo_mag == '0) && (hi_mag == '0);
    assign k_lo      = -$signed(OFF_W'(lo_mag));

    always_comb begin
        if (lo_mag != '0) begin
            k_first = k_lo;
        end else if (empty_now) begin
            k_first = '0;
        end else begin
            k_first = K_ONE;
        end
    end

    assign k_end  = (hi_mag != '0) ? $signed(OFF_W'(hi_mag)) : K_NEG1;
    assign k_step = (k_reg == K_NEG1) ? K_ONE : (k_reg + K_ONE);

    assign k_ext   = {{(DIST_W - OFF_W){k_reg[OFF_W-1]}}, k_reg};
    assign nb_dist = $signed({2'b00, dc_reg}) - k_ext;

    assign rd_dist = cmd.start ? $signed({2'b00, dc_sat}) : nb_dist;
    assign rd_ok   = !rd_dist[DIST_W-1] && (unsigned'(rd_dist) < DIST_W'(HIST_DEPTH));
    assign rd_idx  = rd_dist[HI_W-1:0];
    assign rd_data = rd_ok ? hist_reg[rd_idx] : '0;

    assign k_last  = empty_reg || (k_reg == k_end_reg);
    assign next_ok = (dc_reg != '0) && (flush_reg || (dc_reg > DC_W'(w_eff)));

    assign stat.k_last   = k_last;
    assign stat.out_free = !m_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WIN_RESET;
            count_reg   <= '0;
            last_reg    <= '0;
            c_reg       <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                win_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                if (!sat) begin
                    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    hist_reg[0] <= in_token;
                    count_reg   <= count_reg + POS_BITS'(1);
                end
                last_reg  <= last_next;
                flush_reg <= in_last;
            end
            if (cmd.next_c) begin
                c_reg <= c_reg + POS_BITS'(1);
            end
            if (cmd.finish && flush_reg) begin
                count_reg <= '0;
                c_reg     <= '0;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    hist_reg[i] <= '0;
                end
            end
            m_valid_reg <= cmd.emit | (m_valid_reg & ~out_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dc_reg    <= dc_sat;
            k_reg     <= k_first;
            k_end_reg <= k_end;
            empty_reg <= empty_now;
            cid_reg   <= rd_data;
        end else if (cmd.step) begin
            k_reg <= k_step;
        end
        if (cmd.emit) begin
            out_center_id   <= cid_reg;
            out_cpos        <= c_reg;
            out_context_id  <= empty_reg ? '0 : rd_data;
            out_rel_offset  <= empty_reg ? '0 : k_reg;
            out_has_context <= !empty_reg;
            out_center_done <= k_last;
            out_run_last    <= k_last && !next_ok;
        end
    end

    assign out_valid = m_valid_reg;

endmodule

// File: sv/skipgram_context_window_unit.sv
// Channel  Dir  Beat contents (tdata from bit 0 up / tuser / tlast)
// s_       in   tdata: token_id                   tlast: seq_last
// m_       out  tdata: center_id, center position, context_id, rel_offset
//               tuser: has_context, center_done    tlast: run_last
// cfg_     in   cfg_wr_data: window_size, taken when cfg_wr_en is high
//
// One input beat at a time: accept in ST_IDLE, then per completed center a check
// in ST_CHECK and one result per emit in ST_EMIT (2W neighbors, fewer at sequence
// edges, one for an empty center), then a closing check back to ST_IDLE.
// A flush beat emits every pending center back to back through the same sequencer.
// Reset is synchronous; no clearing pass, s_tready is high right after reset.
// m_tready low holds the result sequencer; s_tready stays low from accept through
// the closing cycle that follows the last result of the beat.
module skipgram_context_window_unit
    import sgcw_pkg::*;
#(
    parameter int MAX_WINDOW = 4,
    parameter int ID_BITS    = 16,
    parameter int POS_BITS   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [WIN_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((ID_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // token_id
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // center_id, center position, context_id, rel_offset
    output logic [((2 * ID_BITS + POS_BITS + OFF_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]             m_tuser,   // has_context, center_done
    output logic                   m_tlast
);

    localparam int OUT_RAW = 2 * ID_BITS + POS_BITS + OFF_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    sgcw_cmd_t               cmd;
    sgcw_stat_t              stat;
    logic [ID_BITS-1:0]      center_id;
    logic [POS_BITS-1:0]     cpos;
    logic [ID_BITS-1:0]      context_id;
    logic signed [OFF_W-1:0] rel_offset;
    logic                    has_context;
    logic                    center_done;

    sgcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgcw_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .ID_BITS    (ID_BITS),
        .POS_BITS   (POS_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_token        (s_tdata[ID_BITS-1:0]),
        .in_last         (s_tlast),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_center_id   (center_id),
        .out_cpos        (cpos),
        .out_context_id  (context_id),
        .out_rel_offset  (rel_offset),
        .out_has_context (has_context),
        .out_center_done (center_done),
        .out_run_last    (m_tlast)
    );

    assign m_tdata = OUT_W'({rel_offset, context_id, cpos, center_id});
    assign m_tuser = {center_done, has_context};

endmodule

// File: sv/sgcw_checker.sv
`include "assert_macros.svh"

module sgcw_checker
    import sgcw_pkg::*;
#(
    parameter int ID_BITS  = 16,
    parameter int POS_BITS = 32
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [((2 * ID_BITS + POS_BITS + OFF_W + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                m_tlast
);

    localparam int CTX_LSB = ID_BITS + POS_BITS;
    localparam int OFF_LSB = 2 * ID_BITS + POS_BITS;

    logic [OFF_W-1:0]   rel;
    logic [ID_BITS-1:0] ctx;

    assign rel = m_tdata[OFF_LSB +: OFF_W];
    assign ctx = m_tdata[CTX_LSB +: ID_BITS];

    `ASSERT_IMPLY(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))
    `ASSERT_IMPLY(a_run_last_done, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1])
    `ASSERT_IMPLY(a_empty_center, aclk, aresetn, m_tvalid && !m_tuser[0], m_tuser[1] && ctx == '0 && rel == '0)
    `ASSERT_IMPLY(a_offset_nonzero, aclk, aresetn, m_tvalid && m_tuser[0], rel != '0)
    `ASSERT_IMPLY(a_one_beat_at_once, aclk, aresetn, s_tvalid && s_tready, ##1 !s_tready)

endmodule

bind skipgram_context_window_unit sgcw_checker #(
    .ID_BITS  (ID_BITS),
    .POS_BITS (POS_BITS)
) u_sgcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/tb_skipgram_context_window_unit.sv
module tb_skipgram_context_window_unit
    import sgcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ID_W        = 16;
    localparam int          POS_W       = 32;
    localparam int          TOK_TDATA_W = 16;
    localparam int          PAIR_TDATA_W = 72;
    localparam int          MAX_WIN     = 4;
    localparam int          HIST_N      = 2 * MAX_WIN + 1;
    localparam int          RESULT_CAP  = 40;
    localparam logic [63:0] POS_MAX     = 64'hFFFF_FFFF;
    localparam int          SETTLE      = 20;
    localparam int          HOLD_CYCLES = 400;
    localparam int          LIMIT       = 1_000_000;
    localparam int          N_DIR       = 25;
    localparam int          N_PHASE     = 8;

    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_QUIET,
        ROW_SOLO
    } row_kind_t;

    typedef struct packed {
        logic               cfg_en;
        logic [WIN_W-1:0]   cfg_val;
        logic [ID_W-1:0]    tok;
        logic               last;
        row_kind_t          kind;
    } dir_row_t;

    typedef struct packed {
        logic [ID_W-1:0]        center_id;
        logic [POS_W-1:0]       cpos;
        logic [ID_W-1:0]        context_id;
        logic signed [OFF_W-1:0] rel_offset;
        logic                   has_context;
        logic                   center_done;
        logic                   run_last;
    } pair_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [WIN_W-1:0]        cfg_wr_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [TOK_TDATA_W-1:0]  s_tdata;   // token_id
    logic                    s_tlast;   // seq_last
    logic                    m_tvalid;
    logic                    m_tready;
    logic [PAIR_TDATA_W-1:0] m_tdata;   // center_id, center position, context_id, rel_offset
    logic [1:0]              m_tuser;   // has_context, center_done
    logic                    m_tlast;   // run_last

    skipgram_context_window_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, 3'd0, 16'hFFFF, 1'b1, ROW_SOLO},
        '{1'b0, 3'd0, 16'h0000, 1'b1, ROW_SOLO},
        '{1'b0, 3'd0, 16'h1234, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hABCD, 1'b1, ROW_CHECKED},
        '{1'b1, 3'd0, 16'h5555, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hAAAA, 1'b0, ROW_CHECKED},
        '{1'b0, 3'd0, 16'h0001, 1'b0, ROW_CHECKED},
        '{1'b0, 3'd0, 16'h8000, 1'b1, ROW_CHECKED},
        '{1'b1, 3'd4, 16'h7FFF, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'h0F0F, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hF0F0, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'h00FF, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hFF00, 1'b0, ROW_CHECKED},
        '{1'b0, 3'd0, 16'h3C3C, 1'b0, ROW_CHECKED},
        '{1'b1, 3'd1, 16'hC3C3, 1'b0, ROW_CHECKED},
        '{1'b0, 3'd0, 16'h6666, 1'b1, ROW_CHECKED},
        '{1'b1, 3'd7, 16'h1111, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'h2222, 1'b1, ROW_CHECKED},
        '{1'b1, 3'd5, 16'h4321, 1'b1, ROW_SOLO},
        '{1'b1, 3'd6, 16'h0000, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hFFFF, 1'b1, ROW_CHECKED},
        '{1'b1, 3'd3, 16'h1357, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'h2468, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'h9ABC, 1'b0, ROW_QUIET},
        '{1'b0, 3'd0, 16'hDEF0, 1'b0, ROW_CHECKED}
    };

    int ph_win   [N_PHASE] = '{1, 4, 2, 7, 3, 0, 4, 5};
    int ph_tx    [N_PHASE] = '{32, 32, 83, 83, 0, 0, 0, 0};
    int ph_rx    [N_PHASE] = '{83, 83, 32, 32, 0, 0, 0, 0};
    int ph_items [N_PHASE] = '{50, 60, 50, 60, 50, 50, 60, 30};
    bit ph_hold  [N_PHASE] = '{0, 1, 0, 0, 0, 0, 1, 0};

    logic [ID_W-1:0]  hist [HIST_N] = '{default: '0};
    logic [63:0]      pos_count = '0;
    logic [63:0]      next_ctr  = '0;
    logic [WIN_W-1:0] win_cfg   = WIN_RESET;

    pair_t pair_q [$];
    pair_t step_pairs [$];
    pair_t got_pair;
    pair_t want_pair;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold_req = 1'b0;
    int  seq_left    = 0;
    int  n_errors    = 0;
    int  n_tokens    = 0;
    int  n_seqs      = 0;
    int  n_pairs     = 0;
    int  n_empty     = 0;
    int  n_cycles    = 0;

    function automatic logic [ID_W-1:0] pick_id(input logic [63:0] last_pos,
                                                  input logic [63:0] pos);
        logic [63:0] gap;
        if (pos > last_pos) begin
            return '0;
        end
        gap = last_pos - pos;
        if (gap >= HIST_N) begin
            return '0;
        end
        return hist[gap[3:0]];
    endfunction

    function automatic void predict_step(input logic [ID_W-1:0] tok, input logic flush);
        logic [63:0] w;
        logic [63:0] last_pos;
        logic [63:0] c;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] j;
        logic [63:0] rel;
        logic [ID_W-1:0] cid;
        bit any;
        step_pairs.delete();
        w = 64'(win_cfg);
        if (w < 1) w = 1;
        if (w > MAX_WIN) w = MAX_WIN;
        if (pos_count < POS_MAX) begin
            for (int i = HIST_N - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = tok;
            pos_count = pos_count + 1;
        end
        last_pos = pos_count - 1;
        c = next_ctr;
        while (c <= last_pos && (flush || c + w <= last_pos)) begin
            lo  = (c >= w) ? c - w : 64'd0;
            hi  = (c + w < last_pos) ? c + w : last_pos;
            cid = pick_id(last_pos, c);
            any = 1'b0;
            for (j = lo; j <= hi; j++) begin
                if (j != c && step_pairs.size() < RESULT_CAP) begin
                    rel = j - c;
                    step_pairs.push_back('{cid, c[POS_W-1:0], pick_id(last_pos, j),
                                           rel[OFF_W-1:0], 1'b1, 1'b0, 1'b0});
                    any = 1'b1;
                end
            end
            if (!any && step_pairs.size() < RESULT_CAP) begin
                step_pairs.push_back('{cid, c[POS_W-1:0], '0, '0, 1'b0, 1'b0, 1'b0});
                any = 1'b1;
            end
            if (any) step_pairs[$].center_done = 1'b1;
            c = c + 1;
        end
        next_ctr = c;
        if (step_pairs.size() > 0) step_pairs[$].run_last = 1'b1;
        if (flush) begin
            for (int i = 0; i < HIST_N; i++) hist[i] = '0;
            pos_count = '0;
            next_ctr  = '0;
        end
    endfunction

    task automatic send_token(input logic [ID_W-1:0] tok, input logic last,
                              input row_kind_t kind);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_step(tok, last);
        case (kind)
            ROW_CHECKED: begin
                foreach (step_pairs[i]) pair_q.push_back(step_pairs[i]);
            end
            ROW_SOLO: begin
                pair_q.push_back('{tok, 32'd0, 16'd0, 4'sd0, 1'b0, 1'b1, 1'b1});
            end
            default: begin
            end
        endcase
        n_tokens++;
        if (last) n_seqs++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pair_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] val);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        win_cfg      = val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : clock_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("%0t: timeout with %0d pairs outstanding", $time, pair_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_pair = '{m_tdata[15:0], m_tdata[47:16], m_tdata[63:48], m_tdata[67:64],
                         m_tuser[0], m_tuser[1], m_tlast};
            if (pair_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat, expected none, actual cid=%h pos=%0d ctx=%h",
                         $time, got_pair.center_id, got_pair.cpos, got_pair.context_id);
            end else begin
                want_pair = pair_q.pop_front();
                n_pairs++;
                if (!got_pair.has_context) n_empty++;
                if (got_pair.center_id   !== want_pair.center_id   ||
                    got_pair.cpos        !== want_pair.cpos        ||
                    got_pair.context_id  !== want_pair.context_id  ||
                    got_pair.rel_offset  !== want_pair.rel_offset  ||
                    got_pair.has_context !== want_pair.has_context ||
                    got_pair.center_done !== want_pair.center_done ||
                    got_pair.run_last    !== want_pair.run_last) begin
                    n_errors++;
                    $display("%0t: mismatch expected cid=%h pos=%0d ctx=%h off=%0d has=%b done=%b last=%b",
                             $time, want_pair.center_id, want_pair.cpos,
                             want_pair.context_id, want_pair.rel_offset,
                             want_pair.has_context, want_pair.center_done, want_pair.run_last);
                    $display("%0t:          actual cid=%h pos=%0d ctx=%h off=%0d has=%b done=%b last=%b",
                             $time, got_pair.center_id, got_pair.cpos,
                             got_pair.context_id, got_pair.rel_offset,
                             got_pair.has_context, got_pair.center_done, got_pair.run_last);
                end
            end
        end
    end

    initial begin : stimulus
        dir_row_t        row;
        logic [ID_W-1:0] tok;
        logic            last;
        int              pick;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 32;
        rx_idle_pct = 83;
        for (int k = 0; k < N_DIR; k++) begin
            row = dir_rows[k];
            if (row.cfg_en) set_window(row.cfg_val);
            send_token(row.tok, row.last, row.kind);
        end

        for (int p = 0; p < N_PHASE; p++) begin
            set_window(WIN_W'(ph_win[p]));
            tx_idle_pct = ph_tx[p];
            rx_idle_pct = ph_rx[p];
            if (ph_hold[p]) rx_hold_req = 1'b1;
            for (int n = 0; n < ph_items[p]; n++) begin
                if (seq_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) seq_left = $urandom_range(1, 10);
                    else if (pick < 95) seq_left = $urandom_range(11, 24);
                    else seq_left = $urandom_range(30, 45);
                end
                pick = $urandom_range(0, 99);
                if (pick < 5) tok = '0;
                else if (pick < 10) tok = '1;
                else tok = ID_W'($urandom_range(0, 65535));
                // truncate a sequence now and then
                last = (seq_left == 1) || ($urandom_range(0, 99) < 3);
                seq_left = last ? 0 : seq_left - 1;
                send_token(tok, last, ROW_CHECKED);
            end
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d tokens in %0d sequences, %0d pairs checked (%0d empty centers),",
                 n_tokens, n_seqs, n_pairs, n_empty);
        $display("window settings 0 to 7, idle mixes on both sides, %0d-cycle receiver stalls.",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/sgcw_pkg.sv
sv/sgcw_ctrl.sv
sv/sgcw_dpath.sv
sv/skipgram_context_window_unit.sv
sv/sgcw_checker.sv
sim/tb_skipgram_context_window_unit.sv
